// File: src/knn_pkg.sv
// Package for the k-nearest-neighbor search unit: sizes, codes and entry type
// shared by the top level and the sorting cells, and the ordering function the cells use.
// No dependencies.
`timescale 1ns / 1ps
package knn_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_DIM     = 128;
    localparam int MAX_K       = 64;

    localparam int ID_W    = 32;
    localparam int ELEM_VW = 16;
    localparam int DIST_W  = 40;
    localparam int LEN_W   = 8;
    localparam int NCNT_W  = 7;
    localparam int CFG_W   = 8;
    localparam int SQ_W    = 34;

    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int ELEM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 2);
    localparam int K_W    = $clog2(MAX_K + 1);
    localparam int STORE_DEPTH = MAX_ENTRIES << ELEM_W;

    localparam int VL_RESET = 128;
    localparam int NC_RESET = 8;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } knn_action_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_LEN      = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_EMPTY    = 3'd4
    } knn_status_t;

    typedef enum logic {
        CFG_VLEN = 1'b0,
        CFG_NCNT = 1'b1
    } knn_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_FIN,
        ST_ELEM,
        ST_DRAIN,
        ST_INS,
        ST_QEND,
        ST_CP,
        ST_CPEND,
        ST_RESP,
        ST_EMIT
    } knn_state_t;

    // One ranked candidate
    typedef struct packed {
        logic                     vld;
        logic [DIST_W-1:0]        score;
        logic signed [ID_W-1:0]   id;
    } knn_ent_t;

    // Controls broadcast along the cell row
    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } knn_ctl_t;

    // Candidate ranks ahead of held entry: held entry empty, or smaller distance, then smaller id
    function automatic logic knn_better(input knn_ent_t c, input knn_ent_t m);
        logic res;
        res = !m.vld || (c.score < m.score) || ((c.score == m.score) && (c.id < m.id));
        return res;
    endfunction

endpackage

// File: src/knn_if.sv
// Stream channel interfaces of the k-nearest-neighbor search unit.
// Depends on knn_pkg for field widths.
`timescale 1ns / 1ps
interface knn_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            action;
    logic signed [knn_pkg::ID_W-1:0]       entry_id;
    logic signed [knn_pkg::ELEM_VW-1:0]    element_value;
    logic                                  last_element;

    modport source (output valid, action, entry_id, element_value, last_element,
                    input ready);
    modport sink   (input valid, action, entry_id, element_value, last_element,
                    output ready);
endinterface

interface knn_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [knn_pkg::ID_W-1:0]       neighbor_id;
    logic [2:0]                            status;
    logic                                  last_result;

    modport source (output valid, neighbor_id, status, last_result, input ready);
    modport sink   (input valid, neighbor_id, status, last_result, output ready);
endinterface

// File: src/brute_force_knn_search_unit.sv
// Exact k-nearest-neighbor search unit: top level with sequencer, distance
// datapath, RAMs and the row of sorting cells. Depends on knn_pkg, knn_if,
// knn_ram and knn_cell.
`timescale 1ns / 1ps
// Vector elements are taken one per cycle while the unit is idle, with no
// result. After reset the unit clears the entry table before it takes its
// first beat; configuration writes are accepted during that time. Remove and
// add walk the whole entry table, reading and checking each slot in turn; an
// add then copies the staged vector into the slot that holds its id, or else
// into the first free slot. A query's last element visits every slot and, for
// each valid entry, reads the stored vector through the single element read
// port of the vector store and sums the squared differences; the nearest
// neighbors are then returned, nearest first. The sorted best list lives in a
// row of MAX_K cells, each holding one ranked candidate.
module brute_force_knn_search_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [knn_pkg::CFG_W-1:0]  cfg_data,
    knn_cmd_if.sink                    cmd,
    knn_res_if.source                  res
);
    import knn_pkg::*;

    // configuration
    logic [LEN_W-1:0]  vlen_reg;
    logic [NCNT_W-1:0] ncnt_reg;

    // sequencer
    knn_state_t             state_reg, state_next;
    knn_action_t            op_reg;
    logic signed [ID_W-1:0] key_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [ELEM_W-1:0]      elem_reg;
    logic                   hit_reg, free_reg;
    logic [SLOT_W-1:0]      hit_slot_reg, free_slot_reg;
    knn_status_t            rsp_status_reg;
    logic [K_W-1:0]         emit_cnt_reg;
    logic signed [ID_W-1:0] cur_id_reg;

    // distance pipeline
    logic              rd_v_reg, rd_last_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic              sq_v_reg, sq_last_reg;
    logic [DIST_W-1:0] acc_reg;
    logic              acc_done_reg;
    logic              cp_v_reg;
    logic [ELEM_W-1:0] cp_idx_reg;

    // output register
    logic                   out_valid_reg;
    logic signed [ID_W-1:0] out_id_reg;
    knn_status_t            out_status_reg;
    logic                   out_last_reg;

    // RAM ports
    logic                       stg_we;
    logic [ELEM_W-1:0]          stg_waddr, stg_raddr;
    logic [ELEM_VW-1:0]         stg_rdata;
    logic                       st_we;
    logic [SLOT_W+ELEM_W-1:0]   st_waddr, st_raddr;
    logic [ELEM_VW-1:0]         st_rdata;
    logic                       id_we;
    logic [SLOT_W-1:0]          id_waddr;
    logic [ID_W:0]              id_wdata, id_rdata;

    // cell row
    knn_ctl_t  ctl;
    knn_ent_t  cand;
    knn_ent_t  cells [MAX_K+1];
    logic      takes [MAX_K];

    // derived control
    logic                   cmd_ready, acc_beat, out_free;
    logic                   is_elem;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   len_ok;
    logic                   slot_last, elem_last;
    logic                   id_v, id_match;
    logic signed [ID_W-1:0] id_val;
    logic [K_W-1:0]         k_eff;
    logic                   emit_last;
    logic                   issue, cp_issue, out_load;
    logic signed [ID_W-1:0] load_id;
    knn_status_t            load_status;
    logic                   load_last;

    assign cmd.ready = cmd_ready;
    assign acc_beat  = cmd.valid && cmd_ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign is_elem   = (cmd.action == ACT_ADD) || (cmd.action == ACT_QUERY);
    assign cnt_inc   = (cnt_reg <= CNT_W'(MAX_DIM)) ? cnt_reg + 1'b1 : cnt_reg;
    assign len_ok    = (vlen_reg != '0) && (16'(vlen_reg) <= 16'(MAX_DIM))
                    && (16'(cnt_inc) == 16'(vlen_reg));
    assign slot_last = (slot_reg == SLOT_W'(MAX_ENTRIES - 1));
    assign elem_last = (16'(elem_reg) + 16'd1 == 16'(vlen_reg));

    assign id_v     = id_rdata[ID_W];
    assign id_val   = $signed(id_rdata[ID_W-1:0]);
    assign id_match = id_v && (id_val == key_reg);

    assign k_eff = (ncnt_reg == '0) ? K_W'(1)
                 : (ncnt_reg > NCNT_W'(MAX_K)) ? K_W'(MAX_K) : K_W'(ncnt_reg);
    assign emit_last = (emit_cnt_reg + 1'b1 == k_eff) || !cells[1].vld;

    // staging buffer, vector store and entry table
    assign stg_waddr = cnt_reg[ELEM_W-1:0];
    assign stg_raddr = elem_reg;
    assign st_raddr  = {slot_reg, elem_reg};
    assign st_we     = cp_v_reg;
    assign st_waddr  = {slot_reg, cp_idx_reg};

    knn_ram #(.WIDTH(ELEM_VW), .DEPTH(MAX_DIM)) u_stage (
        .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(cmd.element_value),
        .raddr(stg_raddr), .rdata(stg_rdata)
    );

    knn_ram #(.WIDTH(ELEM_VW), .DEPTH(STORE_DEPTH)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(stg_rdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    knn_ram #(.WIDTH(ID_W + 1), .DEPTH(MAX_ENTRIES)) u_ids (
        .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
        .raddr(slot_reg), .rdata(id_rdata)
    );

    // row of sorting cells
    assign cand.vld   = 1'b1;
    assign cand.score = acc_reg;
    assign cand.id    = cur_id_reg;
    assign cells[MAX_K] = '0;

    for (genvar g = 0; g < MAX_K; g++)
    begin : g_cell
        knn_ent_t prev_ent;
        logic     prev_tk;
        if (g == 0)
        begin : g_head
            assign prev_ent = '0;
            assign prev_tk  = 1'b0;
        end
        else
        begin : g_body
            assign prev_ent = cells[g-1];
            assign prev_tk  = takes[g-1];
        end
        knn_cell u_cell (
            .clk(clk), .rst_n(rst_n), .ctl(ctl), .cand(cand),
            .prev(prev_ent), .prev_take(prev_tk), .nxt(cells[g+1]),
            .ent(cells[g]), .take(takes[g])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (slot_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc_beat)
                begin
                    if (cmd.action == ACT_REMOVE)
                    begin
                        state_next = ST_RD;
                    end
                    else if (is_elem && cmd.last_element)
                    begin
                        state_next = len_ok ? ST_RD : ST_RESP;
                    end
                end
            end
            ST_RD:    state_next = ST_CHK;
            ST_CHK:
            begin
                if (op_reg == ACT_QUERY)
                begin
                    if (id_v)
                    begin
                        state_next = ST_ELEM;
                    end
                    else
                    begin
                        state_next = slot_last ? ST_QEND : ST_RD;
                    end
                end
                else
                begin
                    state_next = slot_last ? ST_FIN : ST_RD;
                end
            end
            ST_FIN:
            begin
                state_next = ((op_reg == ACT_ADD) && (hit_reg || free_reg)) ? ST_CP : ST_RESP;
            end
            ST_ELEM:  state_next = elem_last ? ST_DRAIN : ST_ELEM;
            ST_DRAIN: state_next = acc_done_reg ? ST_INS : ST_DRAIN;
            ST_INS:   state_next = slot_last ? ST_QEND : ST_RD;
            ST_QEND:  state_next = cells[0].vld ? ST_EMIT : ST_RESP;
            ST_CP:    state_next = elem_last ? ST_CPEND : ST_CP;
            ST_CPEND: state_next = ST_RESP;
            ST_RESP:  state_next = out_free ? ST_IDLE : ST_RESP;
            ST_EMIT:  state_next = (out_free && emit_last) ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_ready   = 1'b0;
        stg_we      = 1'b0;
        id_we       = 1'b0;
        id_waddr    = slot_reg;
        id_wdata    = '0;
        ctl         = '0;
        issue       = 1'b0;
        cp_issue    = 1'b0;
        out_load    = 1'b0;
        load_id     = '0;
        load_status = rsp_status_reg;
        load_last   = 1'b1;
        unique case (state_reg)
            ST_CLR:
            begin
                id_we = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                stg_we    = acc_beat && is_elem && (cnt_reg < CNT_W'(MAX_DIM));
                ctl.clear = acc_beat && (cmd.action == ACT_QUERY) && cmd.last_element;
            end
            ST_FIN:
            begin
                if ((op_reg == ACT_REMOVE) && hit_reg)
                begin
                    id_we    = 1'b1;
                    id_waddr = hit_slot_reg;
                    id_wdata = {1'b0, key_reg};
                end
            end
            ST_ELEM:
            begin
                issue = 1'b1;
            end
            ST_INS:
            begin
                ctl.insert = 1'b1;
            end
            ST_CP:
            begin
                cp_issue = 1'b1;
            end
            ST_CPEND:
            begin
                id_we    = 1'b1;
                id_wdata = {1'b1, key_reg};
            end
            ST_RESP:
            begin
                out_load = out_free;
            end
            ST_EMIT:
            begin
                out_load    = out_free;
                ctl.shift   = out_free;
                load_id     = cells[0].id;
                load_status = STAT_OK;
                load_last   = emit_last;
            end
            default:
            begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= LEN_W'(VL_RESET);
            ncnt_reg <= NCNT_W'(NC_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_VLEN: vlen_reg <= cfg_data[LEN_W-1:0];
                CFG_NCNT: ncnt_reg <= cfg_data[NCNT_W-1:0];
                default:  vlen_reg <= vlen_reg;
            endcase
        end
    end

    // sequencer state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            op_reg         <= ACT_NONE;
            cnt_reg        <= '0;
            slot_reg       <= '0;
            elem_reg       <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            rsp_status_reg <= STAT_OK;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLR:
                begin
                    slot_reg <= slot_last ? '0 : slot_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (acc_beat)
                    begin
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                        slot_reg <= '0;
                        op_reg   <= knn_action_t'(cmd.action);
                        if (is_elem)
                        begin
                            cnt_reg <= cmd.last_element ? '0 : cnt_inc;
                            if (cmd.last_element && !len_ok)
                            begin
                                rsp_status_reg <= STAT_LEN;
                            end
                        end
                    end
                end
                ST_CHK:
                begin
                    if (id_match && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!id_v && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                    elem_reg <= '0;
                    if (!((op_reg == ACT_QUERY) && id_v) && !slot_last)
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                ST_FIN:
                begin
                    elem_reg <= '0;
                    if (op_reg == ACT_REMOVE)
                    begin
                        rsp_status_reg <= hit_reg ? STAT_OK : STAT_NOTFOUND;
                    end
                    else if (hit_reg)
                    begin
                        slot_reg <= hit_slot_reg;
                    end
                    else if (free_reg)
                    begin
                        slot_reg <= free_slot_reg;
                    end
                    else
                    begin
                        rsp_status_reg <= STAT_FULL;
                    end
                end
                ST_ELEM, ST_CP:
                begin
                    if (!elem_last)
                    begin
                        elem_reg <= elem_reg + 1'b1;
                    end
                end
                ST_INS:
                begin
                    if (!slot_last)
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                ST_QEND:
                begin
                    emit_cnt_reg   <= '0;
                    rsp_status_reg <= STAT_EMPTY;
                end
                ST_CPEND:
                begin
                    rsp_status_reg <= STAT_OK;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        emit_cnt_reg <= emit_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        if (acc_beat)
        begin
            key_reg <= cmd.entry_id;
        end
        if (state_reg == ST_CHK)
        begin
            if (id_match && !hit_reg)
            begin
                hit_slot_reg <= slot_reg;
            end
            if (!id_v && !free_reg)
            begin
                free_slot_reg <= slot_reg;
            end
            cur_id_reg <= id_val;
        end
    end

    // distance pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg     <= 1'b0;
            sq_v_reg     <= 1'b0;
            acc_done_reg <= 1'b0;
            cp_v_reg     <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= issue;
            sq_v_reg     <= rd_v_reg;
            acc_done_reg <= sq_v_reg && sq_last_reg;
            cp_v_reg     <= cp_issue;
        end
    end

    // square differences and accumulate
    always_ff @(posedge clk)
    begin
        logic signed [ELEM_VW:0]  diff;
        logic signed [2*ELEM_VW+1:0] prod;
        diff = $signed({stg_rdata[ELEM_VW-1], stg_rdata})
             - $signed({st_rdata[ELEM_VW-1], st_rdata});
        prod = diff * diff;
        rd_last_reg <= issue && elem_last;
        sq_last_reg <= rd_last_reg;
        cp_idx_reg  <= elem_reg;
        sq_reg      <= SQ_W'(prod);
        if (state_reg == ST_CHK)
        begin
            acc_reg <= '0;
        end
        else if (sq_v_reg)
        begin
            acc_reg <= acc_reg + DIST_W'(sq_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_id_reg     <= load_id;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.neighbor_id = out_id_reg;
    assign res.status      = out_status_reg;
    assign res.last_result = out_last_reg;

    // the best list stays packed toward the head
    a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
        cells[1].vld |-> cells[0].vld)
        else $error("best list has a gap at the head");

    // never return more neighbors than the effective count k_eff
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (emit_cnt_reg < k_eff))
        else $error("emitted more neighbors than the count");

    // a finished distance lands only while waiting for it
    a_acc_drain: assert property (@(posedge clk) disable iff (!rst_n)
        acc_done_reg |-> (state_reg == ST_DRAIN))
        else $error("distance finished outside drain");

    // vector store written only by the copy
    a_copy_win: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> ((state_reg == ST_CP) || (state_reg == ST_CPEND)))
        else $error("vector store written outside copy");

endmodule

// File: src/knn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/knn_cell.sv
// One cell of the sorted best-candidate row: holds one ranked entry, takes a
// new candidate or its upper neighbor's entry on insert, and the lower one on shift.
// Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  knn_pkg::knn_ctl_t  ctl,
    input  knn_pkg::knn_ent_t  cand,
    input  knn_pkg::knn_ent_t  prev,
    input  logic               prev_take,
    input  knn_pkg::knn_ent_t  nxt,
    output knn_pkg::knn_ent_t  ent,
    output logic               take
);
    import knn_pkg::*;

    logic                   vld_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic signed [ID_W-1:0] id_reg;

    assign ent.vld   = vld_reg;
    assign ent.score = dist_reg;
    assign ent.id    = id_reg;

    // candidate outranks the held entry
    assign take = knn_better(cand, ent);

    // hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            vld_reg <= nxt.vld;
        end
        else if (ctl.insert)
        begin
            if (prev_take)
            begin
                vld_reg <= prev.vld;
            end
            else if (take)
            begin
                vld_reg <= 1'b1;
            end
        end
    end

    // move payload down on insert, up on shift
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            dist_reg <= nxt.score;
            id_reg   <= nxt.id;
        end
        else if (ctl.insert)
        begin
            if (prev_take)
            begin
                dist_reg <= prev.score;
                id_reg   <= prev.id;
            end
            else if (take)
            begin
                dist_reg <= cand.score;
                id_reg   <= cand.id;
            end
        end
    end
endmodule

// File: dv/testbench.sv
// Self-checking testbench for brute_force_knn_search_unit: directed and random
// add, remove and query traffic checked against a built-in table model.
// Depends on knn_pkg, knn_if and the unit under test.
`timescale 1ns / 1ps
module testbench;
    import knn_pkg::*;

    typedef struct {
        knn_action_t action;
        int          id;
        shortint     elem;
        bit          last;
    } cmd_beat_t;

    typedef struct {
        int          id;
        knn_status_t status;
        bit          last;
    } knn_result_t;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 50;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    knn_cmd_if cmd_ch ();
    knn_res_if res_ch ();

    brute_force_knn_search_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Table mirror
    shortint     tbl_vec [MAX_ENTRIES][MAX_DIM];
    int          tbl_id [MAX_ENTRIES];
    bit          tbl_vld [MAX_ENTRIES];
    shortint     stage_vec [MAX_DIM];
    int unsigned stage_cnt;
    int unsigned vec_len;
    int unsigned nbr_cnt;

    cmd_beat_t   pending_beats [$];
    knn_result_t expected_results [$];

    int  idle_mode;
    int  mismatches = 0;
    int  beats_sent = 0;
    int  results_checked = 0;
    int  quiet_cycles = 0;
    int  id_pool [16];

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned sq_dist(int slot);
        longint unsigned sum;
        int diff;
        sum = 0;
        for (int i = 0; i < vec_len && i < MAX_DIM; i++)
        begin
            diff = int'(stage_vec[i]) - int'(tbl_vec[slot][i]);
            if (diff < 0)
                diff = -diff;
            sum += longint'(diff) * longint'(diff);
        end
        return sum;
    endfunction

    function automatic void push_result(int id, knn_status_t st, bit last);
        knn_result_t r;
        r.id = id;
        r.status = st;
        r.last = last;
        expected_results = {expected_results, r};
    endfunction

    // Rank every valid entry and queue the nearest ids
    function automatic void predict_query();
        longint unsigned dist_of [MAX_ENTRIES];
        bit taken [MAX_ENTRIES];
        int k;
        int best;
        int picked [$];
        for (int s = 0; s < MAX_ENTRIES; s++)
        begin
            taken[s] = 1'b0;
            if (tbl_vld[s])
                dist_of[s] = sq_dist(s);
        end
        k = (nbr_cnt == 0) ? 1 : (nbr_cnt > MAX_K) ? MAX_K : int'(nbr_cnt);
        while (picked.size() < k)
        begin
            best = -1;
            for (int s = 0; s < MAX_ENTRIES; s++)
            begin
                if (tbl_vld[s] && !taken[s])
                begin
                    if (best < 0 || dist_of[s] < dist_of[best] ||
                        (dist_of[s] == dist_of[best] && tbl_id[s] < tbl_id[best]))
                        best = s;
                end
            end
            if (best < 0)
                break;
            taken[best] = 1'b1;
            picked = {picked, tbl_id[best]};
        end
        if (picked.size() == 0)
            push_result(0, STAT_EMPTY, 1'b1);
        foreach (picked[i])
            push_result(picked[i], STAT_OK, i == picked.size() - 1);
    endfunction

    function automatic void predict_add(int id);
        int slot;
        slot = -1;
        for (int s = 0; s < MAX_ENTRIES && slot < 0; s++)
            if (tbl_vld[s] && tbl_id[s] == id)
                slot = s;
        for (int s = 0; s < MAX_ENTRIES && slot < 0; s++)
            if (!tbl_vld[s])
                slot = s;
        if (slot < 0)
        begin
            push_result(0, STAT_FULL, 1'b1);
            return;
        end
        for (int i = 0; i < MAX_DIM; i++)
            tbl_vec[slot][i] = stage_vec[i];
        tbl_id[slot] = id;
        tbl_vld[slot] = 1'b1;
        push_result(0, STAT_OK, 1'b1);
    endfunction

    // Advance the mirror by one accepted command beat
    function automatic void predict_beat(cmd_beat_t b);
        bit found;
        if (b.action == ACT_NONE)
            return;
        if (b.action == ACT_REMOVE)
        begin
            found = 1'b0;
            for (int s = 0; s < MAX_ENTRIES && !found; s++)
            begin
                if (tbl_vld[s] && tbl_id[s] == b.id)
                begin
                    tbl_vld[s] = 1'b0;
                    found = 1'b1;
                end
            end
            push_result(0, found ? STAT_OK : STAT_NOTFOUND, 1'b1);
            return;
        end
        if (stage_cnt < MAX_DIM)
            stage_vec[stage_cnt] = b.elem;
        if (stage_cnt <= MAX_DIM)
            stage_cnt++;
        if (!b.last)
            return;
        if (vec_len < 1 || vec_len > MAX_DIM || stage_cnt != vec_len)
            push_result(0, STAT_LEN, 1'b1);
        else if (b.action == ACT_ADD)
            predict_add(b.id);
        else
            predict_query();
        stage_cnt = 0;
    endfunction

    // Driver: one beat in flight, gaps by phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.action <= ACT_NONE;
            cmd_ch.entry_id <= '0;
            cmd_ch.element_value <= '0;
            cmd_ch.last_element <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (pending_beats.size() != 0 &&
                $urandom_range(0, 99) >= ((idle_mode == 1) ? 72 : (idle_mode == 3) ? 16 : 0))
            begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.action <= pending_beats[0].action;
                cmd_ch.entry_id <= pending_beats[0].id;
                cmd_ch.element_value <= pending_beats[0].elem;
                cmd_ch.last_element <= pending_beats[0].last;
                void'(pending_beats.pop_front());
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls by phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= $urandom_range(0, 99) >=
                ((idle_mode == 2) ? 72 : (idle_mode == 3) ? 16 : 0);
    end

    // Monitor: predict on command beats, check result beats, run watchdog
    always @(posedge clk)
    begin
        cmd_beat_t b;
        knn_result_t e;
        bit moved;
        if (rst_n)
        begin
            moved = (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready);
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                b.action = knn_action_t'(cmd_ch.action);
                b.id = cmd_ch.entry_id;
                b.elem = cmd_ch.element_value;
                b.last = cmd_ch.last_element;
                predict_beat(b);
                beats_sent++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: id %0d status %0d last %0b",
                                 res_ch.neighbor_id, res_ch.status, res_ch.last_result);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (res_ch.neighbor_id !== e.id || res_ch.status !== e.status ||
                        res_ch.last_result !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected id %0d status %0d last %0b,",
                                     e.id, e.status, e.last,
                                     " got id %0d status %0d last %0b",
                                     res_ch.neighbor_id, res_ch.status, res_ch.last_result);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic shortint rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return 16'sh0000;
            default: return shortint'($urandom);
        endcase
    endfunction

    function automatic void queue_beat(knn_action_t act, int id, shortint elem, bit last);
        cmd_beat_t b;
        b.action = act;
        b.id = id;
        b.elem = elem;
        b.last = last;
        pending_beats = {pending_beats, b};
    endfunction

    function automatic void queue_vector(knn_action_t act, int id, int len);
        for (int i = 0; i < len; i++)
            queue_beat(act, id, rand_elem(), i == len - 1);
    endfunction

    // Hold until the unit has drained and every result is back
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || cmd_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(knn_cfg_idx_t idx, int val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_VLEN)
            vec_len = val & 8'hFF;
        else
            nbr_cnt = val & 7'h7F;
    endtask

    // Drop every stored entry so no stale elements are ever compared, then set length, count and idling pattern
    task automatic set_phase(int vl, int k, int mode);
        wait_quiet();
        for (int s = 0; s < MAX_ENTRIES; s++)
            if (tbl_vld[s])
                queue_beat(ACT_REMOVE, tbl_id[s], 16'sh0, 1'b0);
        wait_quiet();
        write_cfg(CFG_VLEN, vl);
        write_cfg(CFG_NCNT, k);
        idle_mode = mode;
    endtask

    task automatic random_traffic(int budget);
        int len;
        int r;
        int start;
        start = beats_sent + pending_beats.size();
        while (beats_sent + pending_beats.size() - start < budget)
        begin
            r = $urandom_range(0, 99);
            len = (vec_len == 0 || vec_len > MAX_DIM) ? $urandom_range(1, 3) : vec_len;
            if ($urandom_range(0, 9) == 0)
                len = (len > 1 && $urandom_range(0, 1)) ? len - 1 : len + 1;
            if (r < 45)
                queue_vector(ACT_ADD, id_pool[$urandom_range(0, 15)], len);
            else if (r < 75)
                queue_vector(ACT_QUERY, $urandom, len);
            else if (r < 88)
                queue_beat(ACT_REMOVE, id_pool[$urandom_range(0, 15)], rand_elem(),
                           $urandom_range(0, 1));
            else if (r < 93)
                queue_beat(ACT_NONE, $urandom, rand_elem(), $urandom_range(0, 1));
            else
                queue_beat(knn_action_t'($urandom_range(0, 1) ? ACT_ADD : ACT_QUERY),
                           $urandom, rand_elem(), 1'b0);
            // Let the driver run a little ahead only
            while (pending_beats.size() > 200)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_VLEN;
        cfg_data = '0;
        idle_mode = 0;
        vec_len = VL_RESET;
        nbr_cnt = NC_RESET;
        stage_cnt = 0;
        for (int s = 0; s < MAX_ENTRIES; s++)
            tbl_vld[s] = 1'b0;
        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7FFF_FFFF;
        id_pool[2] = -1;
        id_pool[3] = 0;
        for (int i = 4; i < 16; i++)
            id_pool[i] = (i < 10) ? i : int'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, replace, ties, length errors
        set_phase(2, 3, 0);
        queue_vector(ACT_QUERY, 0, 2);
        queue_beat(ACT_REMOVE, 5, 16'sh0, 1'b1);
        queue_beat(ACT_ADD, 32'h8000_0000, 16'sh7FFF, 1'b0);
        queue_beat(ACT_ADD, 32'h8000_0000, -16'sh8000, 1'b1);
        queue_beat(ACT_ADD, 32'h7FFF_FFFF, 16'sh0, 1'b0);
        queue_beat(ACT_ADD, 32'h7FFF_FFFF, 16'sh0, 1'b1);
        queue_beat(ACT_ADD, 7, 16'sh0, 1'b0);
        queue_beat(ACT_ADD, 7, 16'sh0, 1'b1);
        queue_beat(ACT_ADD, -1, 16'sh7FFF, 1'b0);
        queue_beat(ACT_ADD, -1, 16'sh7FFF, 1'b1);
        queue_beat(ACT_ADD, 32'h8000_0000, 16'sh1, 1'b0);
        queue_beat(ACT_ADD, 32'h8000_0000, 16'sh1, 1'b1);
        queue_beat(ACT_ADD, 9, 16'sh3, 1'b1);
        queue_vector(ACT_ADD, 9, 3);
        queue_beat(ACT_NONE, 9, 16'sh5, 1'b1);
        queue_beat(ACT_QUERY, 0, 16'sh0, 1'b0);
        queue_beat(ACT_QUERY, 0, 16'sh0, 1'b1);
        queue_beat(ACT_REMOVE, -1, 16'sh0, 1'b0);
        queue_beat(ACT_QUERY, 0, -16'sh8000, 1'b0);
        queue_beat(ACT_ADD, 11, 16'sh7FFF, 1'b1);

        // Random phases over lengths, counts and idling patterns
        random_traffic(18);
        set_phase(4, 1, 1);
        random_traffic(18);
        set_phase(1, 64, 2);
        random_traffic(18);
        set_phase(5, 0, 3);
        random_traffic(18);
        set_phase(3, 127, 0);
        random_traffic(14);
        set_phase(0, 2, 1);
        random_traffic(6);
        set_phase(255, 2, 2);
        random_traffic(6);

        // Longest vectors: count saturation past the limit, then a full-length add
        set_phase(128, 8, 3);
        queue_vector(ACT_ADD, 1, 130);
        queue_vector(ACT_ADD, 1, 128);

        wait_quiet();
        $display("ran %0d command beats and %0d result beats across 8 length and count settings,",
                 beats_sent, results_checked);
        $display("with id extremes, replacements, length errors and all idling patterns");
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing",
                     mismatches, expected_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
